/* rtl/ures_pkg.sv */
// ----------------------------------------------------------------------------
// ures_pkg: shared types and constants for the echo ranging sequencer
// Sequencer phase codes, register map, reset values and distance scaling.
// ----------------------------------------------------------------------------
package ures_pkg;

   // sequencer phase, one-hot
   typedef enum logic [3:0] {
      PH_IDLE   = 4'b0001,
      PH_SETTLE = 4'b0010,
      PH_PULSE  = 4'b0100,
      PH_WAIT   = 4'b1000
   } phase_type;

   // register map (word index in the csr space)
   localparam int unsigned CSR_ADDR_W = 4;
   localparam logic [1:0] REG_SENSOR_COUNT   = 2'd0;
   localparam logic [1:0] REG_ECHO_TIMEOUT   = 2'd1;
   localparam logic [1:0] REG_TRIGGER_WIDTH  = 2'd2;
   localparam logic [1:0] REG_TRIGGER_SETTLE = 2'd3;

   // register reset values
   localparam logic [2:0]  RST_SENSOR_COUNT   = 3'd0;
   localparam logic [15:0] RST_ECHO_TIMEOUT   = 16'd50000;
   localparam logic [7:0]  RST_TRIGGER_WIDTH  = 8'd10;
   localparam logic [7:0]  RST_TRIGGER_SETTLE = 8'd2;

   // field widths
   localparam int unsigned LINE_W  = 4;   // trigger and echo lines
   localparam int unsigned LSEL_W  = 3;   // select into a padded line vector
   localparam int unsigned INDEX_W = 2;
   localparam int unsigned TICK_W  = 16;
   localparam int unsigned DIST_W  = 11;

   localparam logic [TICK_W-1:0] TICK_MAX = '1;

   // distance = floor(ticks * 17 / 1000), kept as a running quotient and remainder
   localparam logic [9:0] DIST_STEP = 10'd17;
   localparam logic [9:0] DIST_DIV  = 10'd1000;

endpackage

/* rtl/ultrasonic_echo_ranging_sequencer_unit.sv */
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranging_sequencer_unit
// Per-tick sequencer that triggers each sensor in turn and times its echo.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+----------------------------------
//   req     | in        | req_valid/req_stall  | start_round, echo_lines
//   rsp     | out       | rsp_valid/rsp_stall  | trigger_lines .. round_done
//   csr     | in/out    | apb, pready always 1 | sensor_count, echo_timeout,
//           |           |                      | trigger_width, trigger_settle
//
// One tick transaction is taken per cycle while not stalled, and its result
// appears in the single output register on the next cycle. The input is
// stalled only while a result waits under rsp_stall. Reset is synchronous:
// it returns the sequencer to idle and loads the register defaults. The
// distance is carried as a running quotient and remainder so no multiplier
// or divider is needed.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranging_sequencer_unit #(
   parameter int unsigned NUM_SENSORS = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   // tick input
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_start_round,
   input  logic [ures_pkg::LINE_W-1:0]       req_echo_lines,
   // result output
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [ures_pkg::LINE_W-1:0]       rsp_trigger_lines,
   output logic                              rsp_report_valid,
   output logic [ures_pkg::INDEX_W-1:0]      rsp_sensor_index,
   output logic [ures_pkg::TICK_W-1:0]       rsp_duration_us,
   output logic [ures_pkg::DIST_W-1:0]       rsp_distance_cm,
   output logic                              rsp_timed_out,
   output logic                              rsp_round_done,
   // configuration
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [ures_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);

   localparam int unsigned SENS_W = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
   localparam logic [3:0]  NUM_SENS4 = 4'(NUM_SENSORS);

   // configuration registers
   logic [2:0]  sensor_count_ff;
   logic [15:0] echo_timeout_ff;
   logic [7:0]  trigger_width_ff;
   logic [7:0]  trigger_settle_ff;

   // sequencer state
   ures_pkg::phase_type               phase_ff,    phase_in;
   logic [SENS_W-1:0]                 sensor_ff,   sensor_in;
   logic [ures_pkg::TICK_W-1:0]       ticks_ff,    ticks_in;
   logic [ures_pkg::TICK_W-1:0]       timer_ff,    timer_in;
   logic                              seen_ff,     seen_in;
   logic [ures_pkg::DIST_W-1:0]       dist_ff,     dist_in;
   logic [9:0]                        rem_ff,      rem_in;

   // result register
   logic                              out_valid_ff;
   logic [ures_pkg::LINE_W-1:0]       trig_ff,     trig_in;
   logic                              report_ff,   report_in;
   logic [ures_pkg::INDEX_W-1:0]      index_ff,    index_in;
   logic [ures_pkg::TICK_W-1:0]       dur_ff,      dur_in;
   logic [ures_pkg::DIST_W-1:0]       distout_ff,  distout_in;
   logic                              tout_ff,     tout_in;
   logic                              done_ff,     done_in;

   logic        req_take;
   logic        csr_write;
   logic [3:0]  active_count;

   // handshake
   assign req_stall = out_valid_ff & rsp_stall;
   assign req_take  = req_valid & ~req_stall;
   assign csr_write = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   // sensor count clamped to the number of sensors built
   assign active_count = ({1'b0, sensor_count_ff} > NUM_SENS4) ? NUM_SENS4
                                                               : {1'b0, sensor_count_ff};

   // register readback
   always_comb begin
      case (csr_paddr[3:2])
         ures_pkg::REG_SENSOR_COUNT:   csr_prdata = {29'd0, sensor_count_ff};
         ures_pkg::REG_ECHO_TIMEOUT:   csr_prdata = {16'd0, echo_timeout_ff};
         ures_pkg::REG_TRIGGER_WIDTH:  csr_prdata = {24'd0, trigger_width_ff};
         ures_pkg::REG_TRIGGER_SETTLE: csr_prdata = {24'd0, trigger_settle_ff};
         default:                      csr_prdata = 32'd0;
      endcase
   end

   // one tick of the sequencer
   always_comb begin
      logic [7:0]                  echo_pad;
      logic [ures_pkg::LSEL_W-1:0] sel;
      logic [7:0]                  trig_pad;
      logic                        level;
      logic                        report;
      logic [10:0]                 rem_sum;

      phase_in   = phase_ff;
      sensor_in  = sensor_ff;
      ticks_in   = ticks_ff;
      timer_in   = timer_ff;
      seen_in    = seen_ff;
      dist_in    = dist_ff;
      rem_in     = rem_ff;
      trig_in    = '0;
      report_in  = 1'b0;
      index_in   = '0;
      dur_in     = '0;
      distout_in = '0;
      tout_in    = 1'b0;
      done_in    = 1'b0;
      report     = 1'b0;
      rem_sum    = '0;

      // start of a round
      if (phase_ff == ures_pkg::PH_IDLE && req_start_round && active_count != 4'd0) begin
         phase_in  = ures_pkg::PH_SETTLE;
         sensor_in = '0;
         ticks_in  = '0;
      end

      sel      = ures_pkg::LSEL_W'(sensor_in);
      echo_pad = {4'd0, req_echo_lines};
      trig_pad = 8'd1 << sel;
      level    = echo_pad[sel];

      // settle: trigger low
      if (phase_in == ures_pkg::PH_SETTLE) begin
         if (ticks_in < {8'd0, trigger_settle_ff}) begin
            ticks_in = ticks_in + 16'd1;
         end else begin
            phase_in = ures_pkg::PH_PULSE;
            ticks_in = '0;
         end
      end

      if (phase_in == ures_pkg::PH_PULSE) begin
         // trigger pulse
         if (ticks_in < {8'd0, trigger_width_ff}) begin
            ticks_in = ticks_in + 16'd1;
            trig_in  = trig_pad[ures_pkg::LINE_W-1:0];
         end else begin
            phase_in = ures_pkg::PH_WAIT;
            ticks_in = '0;
            timer_in = '0;
            seen_in  = 1'b0;
            dist_in  = '0;
            rem_in   = '0;
         end
      end else if (phase_in == ures_pkg::PH_WAIT) begin
         // echo timing
         if (level) begin
            seen_in = 1'b1;
            if (ticks_in != ures_pkg::TICK_MAX) begin
               ticks_in = ticks_in + 16'd1;
               rem_sum  = {1'b0, rem_in} + {1'b0, ures_pkg::DIST_STEP};
               if (rem_sum >= {1'b0, ures_pkg::DIST_DIV}) begin
                  rem_in  = 10'(rem_sum - {1'b0, ures_pkg::DIST_DIV});
                  dist_in = dist_in + 11'd1;
               end else begin
                  rem_in  = rem_sum[9:0];
               end
            end
         end else if (seen_in) begin
            report     = 1'b1;
            dur_in     = ticks_in;
            distout_in = dist_in;
         end

         // timeout, falling edge wins on the same tick
         if (!report) begin
            if (timer_in != ures_pkg::TICK_MAX) begin
               timer_in = timer_in + 16'd1;
            end
            if (echo_timeout_ff != 16'd0 && timer_in >= echo_timeout_ff) begin
               report  = 1'b1;
               tout_in = 1'b1;
            end
         end

         // report and move on
         if (report) begin
            report_in = 1'b1;
            index_in  = ures_pkg::INDEX_W'(sensor_in);
            if (4'(sensor_in) + 4'd1 < active_count) begin
               sensor_in = sensor_in + SENS_W'(1);
               phase_in  = ures_pkg::PH_SETTLE;
            end else begin
               phase_in  = ures_pkg::PH_IDLE;
               done_in   = 1'b1;
            end
            ticks_in = '0;
            timer_in = '0;
            seen_in  = 1'b0;
            dist_in  = '0;
            rem_in   = '0;
         end
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sensor_count_ff   <= ures_pkg::RST_SENSOR_COUNT;
         echo_timeout_ff   <= ures_pkg::RST_ECHO_TIMEOUT;
         trigger_width_ff  <= ures_pkg::RST_TRIGGER_WIDTH;
         trigger_settle_ff <= ures_pkg::RST_TRIGGER_SETTLE;
      end else if (csr_write) begin
         case (csr_paddr[3:2])
            ures_pkg::REG_SENSOR_COUNT:   sensor_count_ff   <= csr_pwdata[2:0];
            ures_pkg::REG_ECHO_TIMEOUT:   echo_timeout_ff   <= csr_pwdata[15:0];
            ures_pkg::REG_TRIGGER_WIDTH:  trigger_width_ff  <= csr_pwdata[7:0];
            ures_pkg::REG_TRIGGER_SETTLE: trigger_settle_ff <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   // sequencer state, advanced once per accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= ures_pkg::PH_IDLE;
         sensor_ff <= '0;
         ticks_ff  <= '0;
         timer_ff  <= '0;
         seen_ff   <= 1'b0;
         dist_ff   <= '0;
         rem_ff    <= '0;
      end else if (req_take) begin
         phase_ff  <= phase_in;
         sensor_ff <= sensor_in;
         ticks_ff  <= ticks_in;
         timer_ff  <= timer_in;
         seen_ff   <= seen_in;
         dist_ff   <= dist_in;
         rem_ff    <= rem_in;
      end
   end

   // result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (req_take) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (req_take) begin
         trig_ff    <= trig_in;
         report_ff  <= report_in;
         index_ff   <= index_in;
         dur_ff     <= dur_in;
         distout_ff <= distout_in;
         tout_ff    <= tout_in;
         done_ff    <= done_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_trigger_lines = trig_ff;
   assign rsp_report_valid  = report_ff;
   assign rsp_sensor_index  = index_ff;
   assign rsp_duration_us   = dur_ff;
   assign rsp_distance_cm   = distout_ff;
   assign rsp_timed_out     = tout_ff;
   assign rsp_round_done    = done_ff;

endmodule
